[src/range_prune_agreement_counter_assert.svh]
// Assertion macros for the range prune agreement counter.
// Used by the RTL files in this folder; needs nothing else.
`ifndef RANGE_PRUNE_AGREEMENT_COUNTER_ASSERT_SVH
`define RANGE_PRUNE_AGREEMENT_COUNTER_ASSERT_SVH

// Condition implies consequence in the same cycle
`define RPAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpac assertion failed");

// Condition implies consequence in the next cycle
`define RPAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpac assertion failed");

`endif

[src/rpac_pkg.sv]
// Shared types and constants for the range prune agreement counter.
// No dependencies; used by rpac_dist and the top level.
`timescale 1ns / 1ps

package rpac_pkg;

	localparam int COORD_W    = 16;
	localparam int MAG_W      = 16;
	localparam int SQ_W       = 32;
	localparam int SUM_W      = 42;
	localparam int DIMS_W     = 11;
	localparam int OUT_CNT_W  = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int MAX_DIMS_DEF   = 1024;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic [DIMS_W-1:0] ORIG_DIMS_RST  = DIMS_W'(128);
	localparam logic [DIMS_W-1:0] TRANS_DIMS_RST = DIMS_W'(32);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS     = 2'd0,
		REG_ORIG_DIMS  = 2'd1,
		REG_TRANS_DIMS = 2'd2
	} cfg_reg_t;

	// Per-step control that travels with a coordinate pair
	typedef struct packed {
		logic is_orig;
		logic is_last;
	} step_t;

	// Finished distances of one vector pair
	typedef struct packed {
		logic [SUM_W-1:0] orig;
		logic [SUM_W-1:0] trans;
	} sums_t;

endpackage

[src/range_prune_agreement_counter.sv]
// Range prune agreement counter: squared L2 distances in two spaces per vector
// pair, radius check and saturating agreement counts. Depends on rpac_pkg and
// rpac_dist.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_stall      data_coord, query_coord
//   result    out_valid / out_stall    inside_original, inside_transformed,
//                                      in_total, in_agree, out_total, out_agree
//   config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; a pair's last request is
// registered, squared, added into the 42-bit sums and registered as a result.
// Reset clears the sums, position and counts; radius resets to 0, dimensions
// to 128 and 32. cfg_ready is always high.
// A stalled result blocks input only when rpac_dist also holds finished sums and
// a further pair's last request reaches the accumulate stage.
`timescale 1ns / 1ps

module range_prune_agreement_counter #(
	parameter int MAX_DIMS   = rpac_pkg::MAX_DIMS_DEF,
	parameter int COUNT_BITS = rpac_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [rpac_pkg::COORD_W-1:0]   data_coord,
	input  logic signed [rpac_pkg::COORD_W-1:0]   query_coord,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  inside_original,
	output logic                                  inside_transformed,
	output logic [rpac_pkg::OUT_CNT_W-1:0]        in_total,
	output logic [rpac_pkg::OUT_CNT_W-1:0]        in_agree,
	output logic [rpac_pkg::OUT_CNT_W-1:0]        out_total,
	output logic [rpac_pkg::OUT_CNT_W-1:0]        out_agree,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rpac_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rpac_pkg::SUM_W-1:0]            cfg_data
);

	localparam int DIMS_W = rpac_pkg::DIMS_W;
	localparam int POS_W  = $clog2(2 * MAX_DIMS + 1);
	localparam int CMP_W  = (POS_W > DIMS_W) ? POS_W : DIMS_W;

	logic [rpac_pkg::SUM_W-1:0] radius_q;
	logic [DIMS_W-1:0]          orig_dims_q;
	logic [DIMS_W-1:0]          trans_dims_q;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] od;
	logic [POS_W-1:0] td;
	logic [POS_W-1:0] total;
	rpac_pkg::step_t  step_in;

	logic                                valid_s1;
	logic signed [rpac_pkg::COORD_W-1:0] data_s1;
	logic signed [rpac_pkg::COORD_W-1:0] query_s1;
	rpac_pkg::step_t                     step_s1;
	logic                                s1_ready;
	logic                                accept;

	logic            dist_in_ready;
	logic            dist_out_valid;
	logic            dist_out_ready;
	rpac_pkg::sums_t dist_sums;

	logic                  res_valid_q;
	logic                  res_load;
	logic                  in_o;
	logic                  in_t;
	logic                  inside_o_q;
	logic                  inside_t_q;
	logic [COUNT_BITS-1:0] in_total_q;
	logic [COUNT_BITS-1:0] in_agree_q;
	logic [COUNT_BITS-1:0] out_total_q;
	logic [COUNT_BITS-1:0] out_agree_q;

	function automatic logic [POS_W-1:0] clamp_dims(input logic [DIMS_W-1:0] d);
		logic [CMP_W-1:0] dx;
		dx = CMP_W'(d);
		if (dx == '0) begin
			clamp_dims = POS_W'(1);
		end else if (dx > CMP_W'(MAX_DIMS)) begin
			clamp_dims = POS_W'(MAX_DIMS);
		end else begin
			clamp_dims = POS_W'(dx);
		end
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
	endfunction

	// Write configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q     <= '0;
			orig_dims_q  <= rpac_pkg::ORIG_DIMS_RST;
			trans_dims_q <= rpac_pkg::TRANS_DIMS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (rpac_pkg::cfg_reg_t'(cfg_index))
				rpac_pkg::REG_RADIUS:     radius_q     <= cfg_data;
				rpac_pkg::REG_ORIG_DIMS:  orig_dims_q  <= cfg_data[DIMS_W-1:0];
				rpac_pkg::REG_TRANS_DIMS: trans_dims_q <= cfg_data[DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	// Classify the incoming request by its position in the vector pair
	assign od       = clamp_dims(orig_dims_q);
	assign td       = clamp_dims(trans_dims_q);
	assign total    = od + td;
	assign pos_next = pos_q + 1'b1;
	assign step_in.is_orig = pos_q < od;
	assign step_in.is_last = pos_next >= total;

	assign s1_ready = !valid_s1 || dist_in_ready;
	assign in_stall = !s1_ready;
	assign accept   = in_valid && s1_ready;

	// Advance the position; wrap after the last coordinate of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= step_in.is_last ? '0 : pos_next;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1  <= data_coord;
			query_s1 <= query_coord;
			step_s1  <= step_in;
		end
	end

	rpac_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (dist_in_ready),
		.in_data   (data_s1),
		.in_query  (query_s1),
		.in_step   (step_s1),
		.out_valid (dist_out_valid),
		.out_ready (dist_out_ready),
		.out_sums  (dist_sums)
	);

	// Compare with the radius and update the counts as a result loads
	assign dist_out_ready = !res_valid_q || !out_stall;
	assign res_load       = dist_out_valid && dist_out_ready;
	assign in_o           = dist_sums.orig <= radius_q;
	assign in_t           = dist_sums.trans <= radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			in_total_q  <= '0;
			in_agree_q  <= '0;
			out_total_q <= '0;
			out_agree_q <= '0;
		end else begin
			if (dist_out_ready) begin
				res_valid_q <= dist_out_valid;
			end
			if (res_load) begin
				if (in_o) begin
					in_total_q <= sat_inc(in_total_q);
					if (in_t) begin
						in_agree_q <= sat_inc(in_agree_q);
					end
				end else begin
					out_total_q <= sat_inc(out_total_q);
					if (!in_t) begin
						out_agree_q <= sat_inc(out_agree_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			inside_o_q <= in_o;
			inside_t_q <= in_t;
		end
	end

	// Counts only change when a result loads, so they drive the outputs directly
	assign out_valid          = res_valid_q;
	assign inside_original    = inside_o_q;
	assign inside_transformed = inside_t_q;
	assign in_total           = rpac_pkg::OUT_CNT_W'(in_total_q);
	assign in_agree           = rpac_pkg::OUT_CNT_W'(in_agree_q);
	assign out_total          = rpac_pkg::OUT_CNT_W'(out_total_q);
	assign out_agree          = rpac_pkg::OUT_CNT_W'(out_agree_q);

	`include "range_prune_agreement_counter_assert.svh"

	`RPAC_ASSERT_SAME(a_in_agree_le_total, clk, arst_n, 1'b1, in_agree_q <= in_total_q)
	`RPAC_ASSERT_SAME(a_out_agree_le_total, clk, arst_n, 1'b1, out_agree_q <= out_total_q)
	`RPAC_ASSERT_SAME(a_pos_bounded, clk, arst_n, 1'b1, pos_q < POS_W'(2 * MAX_DIMS))
	`RPAC_ASSERT_NEXT(a_last_wraps_pos, clk, arst_n, accept && step_in.is_last, pos_q == '0)
	`RPAC_ASSERT_NEXT(a_counts_follow_result, clk, arst_n, res_load,
		(in_total_q + out_total_q) != ($past(in_total_q) + $past(out_total_q))
		|| in_total_q == {COUNT_BITS{1'b1}} || out_total_q == {COUNT_BITS{1'b1}})

endmodule

[src/rpac_dist.sv]
// Squared-difference stage and the two distance accumulators.
// Depends on rpac_pkg; instantiated by range_prune_agreement_counter.
`timescale 1ns / 1ps

module rpac_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [rpac_pkg::COORD_W-1:0] in_data,
	input  logic signed [rpac_pkg::COORD_W-1:0] in_query,
	input  rpac_pkg::step_t                     in_step,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rpac_pkg::sums_t                     out_sums
);

	localparam int SUM_W = rpac_pkg::SUM_W;

	logic signed [rpac_pkg::COORD_W:0] diff;
	logic [rpac_pkg::MAG_W-1:0]        mag;
	logic [rpac_pkg::SQ_W-1:0]         sq;

	logic                      valid_s2;
	logic [rpac_pkg::SQ_W-1:0] sq_s2;
	rpac_pkg::step_t           step_s2;

	logic [SUM_W-1:0] orig_sum_q;
	logic [SUM_W-1:0] trans_sum_q;
	logic [SUM_W:0]   orig_add;
	logic [SUM_W:0]   trans_add;
	logic [SUM_W-1:0] orig_new;
	logic [SUM_W-1:0] trans_new;

	logic            valid_s3;
	rpac_pkg::sums_t sums_s3;
	logic            s3_ready;
	logic            take_s2;
	logic            load_s2;

	// Square the coordinate difference; the magnitude fits in 16 bits
	assign diff = {in_data[rpac_pkg::COORD_W-1], in_data}
		- {in_query[rpac_pkg::COORD_W-1], in_query};
	assign mag  = diff[rpac_pkg::COORD_W] ? rpac_pkg::MAG_W'(-diff)
		: diff[rpac_pkg::MAG_W-1:0];
	assign sq   = mag * mag;

	// Handshake between square, accumulate and result stages
	assign s3_ready = !valid_s3 || out_ready;
	assign take_s2  = valid_s2 && (!step_s2.is_last || s3_ready);
	assign in_ready = !valid_s2 || take_s2;
	assign load_s2  = in_valid && in_ready;

	// Hold the squared term for the accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			sq_s2   <= sq;
			step_s2 <= in_step;
		end
	end

	// Saturating add into the sum of the step's space
	assign orig_add  = {1'b0, orig_sum_q} + (SUM_W + 1)'(sq_s2);
	assign trans_add = {1'b0, trans_sum_q} + (SUM_W + 1)'(sq_s2);
	assign orig_new  = orig_add[SUM_W] ? {SUM_W{1'b1}} : orig_add[SUM_W-1:0];
	assign trans_new = trans_add[SUM_W] ? {SUM_W{1'b1}} : trans_add[SUM_W-1:0];

	// Advance the accumulators; clear them once a pair is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_sum_q  <= '0;
			trans_sum_q <= '0;
		end else if (take_s2) begin
			if (step_s2.is_last) begin
				orig_sum_q  <= '0;
				trans_sum_q <= '0;
			end else if (step_s2.is_orig) begin
				orig_sum_q <= orig_new;
			end else begin
				trans_sum_q <= trans_new;
			end
		end
	end

	// Hold the finished sums until the result stage takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take_s2 && step_s2.is_last) begin
			valid_s3 <= 1'b1;
		end else if (out_ready) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2 && step_s2.is_last) begin
			sums_s3.orig  <= step_s2.is_orig ? orig_new : orig_sum_q;
			sums_s3.trans <= step_s2.is_orig ? trans_sum_q : trans_new;
		end
	end

	assign out_valid = valid_s3;
	assign out_sums  = sums_s3;

	`include "range_prune_agreement_counter_assert.svh"

	`RPAC_ASSERT_NEXT(a_last_clears_sums, clk, arst_n, take_s2 && step_s2.is_last,
		orig_sum_q == '0 && trans_sum_q == '0)
	`RPAC_ASSERT_SAME(a_pending_result_blocks, clk, arst_n,
		valid_s3 && !out_ready && valid_s2 && step_s2.is_last, !take_s2)
	`RPAC_ASSERT_NEXT(a_result_held, clk, arst_n, valid_s3 && !out_ready,
		valid_s3 && $stable(sums_s3))

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for range_prune_agreement_counter: streams coordinate requests, writes the
// radius and dimension registers, and checks every result against a local model.
// Depends on rpac_pkg and the range_prune_agreement_counter RTL.

module tb;

	localparam int COORD_W        = rpac_pkg::COORD_W;
	localparam int MAG_W          = rpac_pkg::MAG_W;
	localparam int SQ_W           = rpac_pkg::SQ_W;
	localparam int SUM_W          = rpac_pkg::SUM_W;
	localparam int DIMS_W         = rpac_pkg::DIMS_W;
	localparam int OUT_CNT_W      = rpac_pkg::OUT_CNT_W;
	localparam int CFG_IDX_W      = rpac_pkg::CFG_IDX_W;
	localparam int MAX_DIMS_DEF   = rpac_pkg::MAX_DIMS_DEF;
	localparam int COUNT_BITS_DEF = rpac_pkg::COUNT_BITS_DEF;
	localparam logic [DIMS_W-1:0] ORIG_DIMS_RST  = rpac_pkg::ORIG_DIMS_RST;
	localparam logic [DIMS_W-1:0] TRANS_DIMS_RST = rpac_pkg::TRANS_DIMS_RST;

	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 456;
	localparam int SETTINGS_PER_PHASE = 4;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PAD_W = SUM_W - DIMS_W;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [SUM_W-1:0] SUM_FULL = '1;

	typedef enum int {
		MODE_NEAR,
		MODE_MID,
		MODE_FAR,
		MODE_EXTREME
	} coord_mode_t;

	typedef struct packed {
		logic                 in_o;
		logic                 in_t;
		logic [OUT_CNT_W-1:0] in_total;
		logic [OUT_CNT_W-1:0] in_agree;
		logic [OUT_CNT_W-1:0] out_total;
		logic [OUT_CNT_W-1:0] out_agree;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] data_coord = '0;
	logic signed [COORD_W-1:0] query_coord = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic inside_original;
	logic inside_transformed;
	logic [OUT_CNT_W-1:0] in_total;
	logic [OUT_CNT_W-1:0] in_agree;
	logic [OUT_CNT_W-1:0] out_total;
	logic [OUT_CNT_W-1:0] out_agree;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SUM_W-1:0] cfg_data = '0;

	// Model copy of registers and state, starting from reset values
	logic [SUM_W-1:0] radius_m = '0;
	logic [DIMS_W-1:0] orig_dims_m = ORIG_DIMS_RST;
	logic [DIMS_W-1:0] trans_dims_m = TRANS_DIMS_RST;
	logic [SUM_W-1:0] orig_acc = '0;
	logic [SUM_W-1:0] trans_acc = '0;
	int unsigned step_pos = 0;
	logic [COUNT_BITS_DEF-1:0] in_total_c = '0;
	logic [COUNT_BITS_DEF-1:0] in_agree_c = '0;
	logic [COUNT_BITS_DEF-1:0] out_total_c = '0;
	logic [COUNT_BITS_DEF-1:0] out_agree_c = '0;

	verdict_t verdict_q[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit holdoff_req = 1'b0;
	int holdoff_left = 0;
	int quiet_cycles = 0;

	range_prune_agreement_counter i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.data_coord         (data_coord),
		.query_coord        (query_coord),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.inside_original    (inside_original),
		.inside_transformed (inside_transformed),
		.in_total           (in_total),
		.in_agree           (in_agree),
		.out_total          (out_total),
		.out_agree          (out_agree),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned clamp_dims(logic [DIMS_W-1:0] d);
		if (d == '0)
			return 1;
		if (d > DIMS_W'(MAX_DIMS_DEF))
			return MAX_DIMS_DEF;
		return 32'(d);
	endfunction

	function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [SQ_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		return s[SUM_W] ? SUM_FULL : s[SUM_W-1:0];
	endfunction

	function automatic logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// Add one squared difference to its space; close the vector pair on the last step
	function automatic void accumulate_step(logic signed [COORD_W-1:0] d,
			logic signed [COORD_W-1:0] q);
		int unsigned od;
		int unsigned total;
		logic signed [COORD_W:0] diff;
		logic [MAG_W-1:0] mag;
		logic [SQ_W-1:0] sq;
		verdict_t v;
		od = clamp_dims(orig_dims_m);
		total = od + clamp_dims(trans_dims_m);
		diff = (COORD_W + 1)'(d) - (COORD_W + 1)'(q);
		mag = MAG_W'(diff < 0 ? -diff : diff);
		sq = SQ_W'(mag) * SQ_W'(mag);
		if (step_pos < od)
			orig_acc = add_sat(orig_acc, sq);
		else
			trans_acc = add_sat(trans_acc, sq);
		step_pos++;
		if (step_pos >= total) begin
			v.in_o = (orig_acc <= radius_m);
			v.in_t = (trans_acc <= radius_m);
			if (v.in_o) begin
				in_total_c = bump(in_total_c);
				if (v.in_t)
					in_agree_c = bump(in_agree_c);
			end else begin
				out_total_c = bump(out_total_c);
				if (!v.in_t)
					out_agree_c = bump(out_agree_c);
			end
			v.in_total = OUT_CNT_W'(in_total_c);
			v.in_agree = OUT_CNT_W'(in_agree_c);
			v.out_total = OUT_CNT_W'(out_total_c);
			v.out_agree = OUT_CNT_W'(out_agree_c);
			verdict_q.insert(verdict_q.size(), v);
			orig_acc = '0;
			trans_acc = '0;
			step_pos = 0;
		end
	endfunction

	function automatic void compare_field(string name, logic [OUT_CNT_W-1:0] exp_v,
			logic [OUT_CNT_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// Track register writes and requests, then check each accepted result
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rpac_pkg::REG_RADIUS:     radius_m = cfg_data;
					rpac_pkg::REG_ORIG_DIMS:  orig_dims_m = cfg_data[DIMS_W-1:0];
					rpac_pkg::REG_TRANS_DIMS: trans_dims_m = cfg_data[DIMS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				accumulate_step(data_coord, query_coord);
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t unexpected result: expected none, got %0b %0b %0d %0d %0d %0d",
						$time, inside_original, inside_transformed,
						in_total, in_agree, out_total, out_agree);
					mismatches++;
				end else begin
					exp_v = verdict_q.pop_front();
					compare_field("inside_original", OUT_CNT_W'(exp_v.in_o),
						OUT_CNT_W'(inside_original));
					compare_field("inside_transformed", OUT_CNT_W'(exp_v.in_t),
						OUT_CNT_W'(inside_transformed));
					compare_field("in_total", exp_v.in_total, in_total);
					compare_field("in_agree", exp_v.in_agree, in_agree);
					compare_field("out_total", exp_v.out_total, out_total);
					compare_field("out_agree", exp_v.out_agree, out_agree);
				end
			end
		end
	end

	// Result side: hold off for a long stretch on request, else stall at random
	always @(posedge clk) begin
		if (holdoff_req) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_req = 1'b0;
		end
		if (holdoff_left > 0) begin
			out_stall <= 1'b1;
			holdoff_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Offer one request after a random gap and hold it until accepted
	task automatic send_coord(input logic signed [COORD_W-1:0] d,
			input logic signed [COORD_W-1:0] q);
		int gap;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_coord <= d;
		query_coord <= q;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid, wait for every expected result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Dimension value with junk above the register width
	function automatic logic [SUM_W-1:0] dims_word(logic [DIMS_W-1:0] d);
		return {PAD_W'($urandom), d};
	endfunction

	task automatic set_regs(input logic [SUM_W-1:0] radius, input logic [DIMS_W-1:0] od,
			input logic [DIMS_W-1:0] td);
		settle();
		write_reg(rpac_pkg::REG_RADIUS, radius);
		write_reg(rpac_pkg::REG_ORIG_DIMS, dims_word(od));
		write_reg(rpac_pkg::REG_TRANS_DIMS, dims_word(td));
	endtask

	function automatic logic signed [COORD_W-1:0] pick_extreme();
		case ($urandom_range(3))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	task automatic send_random_coord(input coord_mode_t mode);
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] q;
		int span;
		d = COORD_W'($urandom);
		q = COORD_W'($urandom);
		span = (mode == MODE_NEAR) ? 64 : 4096;
		case (mode)
			MODE_NEAR, MODE_MID: q = d + COORD_W'($urandom_range(2 * span) - span);
			MODE_EXTREME: begin
				d = pick_extreme();
				q = pick_extreme();
			end
			default: ;
		endcase
		send_coord(d, q);
	endtask

	// Reset dimensions: equal original coordinates, scattered transformed ones
	task automatic test_reset_defaults();
		logic signed [COORD_W-1:0] v;
		repeat (ORIG_DIMS_RST) begin
			v = COORD_W'($urandom);
			send_coord(v, v);
		end
		repeat (TRANS_DIMS_RST)
			send_random_coord(MODE_FAR);
	endtask

	// Extremes, zero radius and the exact radius boundary; every count branch
	task automatic test_radius_boundary();
		set_regs('0, 11'd1, 11'd1);
		send_coord(16'sd0, 16'sd0);
		send_coord(16'sd0, 16'sd0);
		send_coord(16'sh7FFF, 16'sh8000);
		send_coord(16'sh8000, 16'sh7FFF);
		send_coord(16'sh8000, 16'sh8000);
		send_coord(16'sh7FFF, 16'sh7FFF);
		send_coord(16'sd1, 16'sd0);
		send_coord(16'sd0, 16'sd0);
		settle();
		write_reg(rpac_pkg::REG_RADIUS, SUM_W'(65536));
		send_coord(16'sd256, 16'sd0);
		send_coord(-16'sd256, 16'sd0);
		send_coord(16'sd0, 16'sd256);
		send_coord(16'sd257, 16'sd0);
		send_coord(-16'sd257, 16'sd0);
		send_coord(16'sd0, -16'sd257);
		send_coord(16'sd257, 16'sd0);
		send_coord(16'sd0, 16'sd1);
	endtask

	// Zero dimensions act as one each
	task automatic test_zero_dims();
		set_regs(SUM_FULL, 11'd0, 11'd0);
		send_coord(16'sh7FFF, 16'sh8000);
		send_coord(16'sh8000, 16'sh7FFF);
	endtask

	// Register writes between steps of one vector pair
	task automatic test_mid_pair_write();
		set_regs(SUM_W'($urandom_range(1 << 30)), 11'd4, 11'd4);
		repeat (5)
			send_random_coord(MODE_MID);
		settle();
		// shrink the pair below the current position: next step closes it
		write_reg(rpac_pkg::REG_TRANS_DIMS, dims_word(11'd1));
		send_random_coord(MODE_MID);
		set_regs(SUM_FULL, 11'd2, 11'd2);
		repeat (3)
			send_random_coord(MODE_NEAR);
		settle();
		write_reg(rpac_pkg::REG_RADIUS, '0);
		send_random_coord(MODE_NEAR);
		settle();
		// spare index must leave every register alone
		write_reg(REG_SPARE, SUM_W'({$urandom, $urandom}));
		repeat (4)
			send_random_coord(MODE_NEAR);
	endtask

	// Push the transformed sum past its ceiling with 1025 maximal steps
	task automatic test_sum_saturation();
		set_regs(SUM_FULL - 1'b1, 11'd1, 11'd2047);
		send_coord(16'sh7FFF, 16'sh8000);
		repeat (1023) begin
			if ($urandom_range(1))
				send_coord(16'sh7FFF, 16'sh8000);
			else
				send_coord(16'sh8000, 16'sh7FFF);
		end
		settle();
		write_reg(rpac_pkg::REG_ORIG_DIMS, dims_word(11'd2));
		send_coord(16'sh8000, 16'sh7FFF);
		send_coord(16'sh7FFF, 16'sh8000);
	endtask

	// Random pairs over several register settings, some left unfinished
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input bit with_holdoff);
		logic [SUM_W-1:0] radius;
		logic [DIMS_W-1:0] od;
		logic [DIMS_W-1:0] td;
		int sent;
		int total;
		coord_mode_t mode;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
			od = ($urandom_range(7) == 0) ? DIMS_W'($urandom_range(7, 40))
				: DIMS_W'($urandom_range(1, 6));
			td = ($urandom_range(7) == 0) ? DIMS_W'($urandom_range(7, 40))
				: DIMS_W'($urandom_range(1, 6));
			if (with_holdoff && s == 0) begin
				// short pairs so the held-off output backs up into the input
				od = DIMS_W'($urandom_range(1, 3));
				td = DIMS_W'($urandom_range(1, 3));
			end
			case ($urandom_range(3))
				0: radius = SUM_W'($urandom_range(1 << 16));
				1: radius = SUM_W'($urandom_range(1 << 26));
				2: radius = SUM_W'({$urandom_range(1), $urandom});
				default: radius = SUM_W'({$urandom, $urandom});
			endcase
			set_regs(radius, od, td);
			if (with_holdoff && s == 0)
				holdoff_req = 1'b1;
			total = int'(od) + int'(td);
			sent = 0;
			while (sent < RANDOM_ITEMS / (3 * SETTINGS_PER_PHASE)) begin
				mode = coord_mode_t'($urandom_range(3));
				repeat (total)
					send_random_coord(mode);
				sent += total;
			end
			// leave a pair unfinished now and then
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3))
					send_random_coord(MODE_FAR);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 29;
		recv_idle_pct = 61;
		test_reset_defaults();
		test_radius_boundary();
		test_zero_dims();
		test_mid_pair_write();
		test_sum_saturation();
		test_random_traffic(29, 61, 1'b0);
		test_random_traffic(61, 29, 1'b0);
		test_random_traffic(0, 0, 1'b1);
		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/rpac_pkg.sv
src/rpac_dist.sv
src/range_prune_agreement_counter.sv
tb/sv/tb.sv
